>>> src/particle_histogram_frame_decoder_defines.svh
// Assertion macros shared by the histogram frame decoder RTL.
`ifndef PARTICLE_HISTOGRAM_FRAME_DECODER_DEFINES_SVH
`define PARTICLE_HISTOGRAM_FRAME_DECODER_DEFINES_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define PHFD_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define PHFD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/phfd_pkg.sv
// Shared constants, field codes and types of the histogram frame decoder.
package phfd_pkg;

    localparam int FRAME_BYTES = 64;
    localparam int POS_W       = $clog2(FRAME_BYTES) + 1;
    localparam int PADDR_W     = 3;

    localparam logic [15:0] CRC_POLY_RESET = 16'hA001;
    localparam logic [15:0] CRC_INIT_RESET = 16'hFFFF;

    // Register indexes on the configuration port.
    localparam logic REG_CRC_POLY = 1'b0;
    localparam logic REG_CRC_INIT = 1'b1;

    // Field codes.
    localparam logic [4:0] CODE_BIN0     = 5'd0;
    localparam logic [4:0] CODE_TOF0     = 5'd16;
    localparam logic [4:0] CODE_FLOW     = 5'd20;
    localparam logic [4:0] CODE_TEMP     = 5'd21;
    localparam logic [4:0] CODE_HUMIDITY = 5'd22;
    localparam logic [4:0] CODE_PERIOD   = 5'd23;
    localparam logic [4:0] CODE_REJECT0  = 5'd24;
    localparam logic [4:0] CODE_PM0      = 5'd26;
    localparam logic [4:0] CODE_CHECKSUM = 5'd29;

    typedef struct packed {
        logic [15:0] poly;
        logic [15:0] init;
    } phfd_cfg_t;

    typedef struct packed {
        logic        done;
        logic [4:0]  code;
        logic [31:0] raw;
        logic [15:0] crc;
    } phfd_result_t;

endpackage

>>> src/phfd_if.sv
// Handshake channels of the histogram frame decoder: frame bytes in, fields out.
interface phfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_start;

    modport source (output valid, output frame_byte, output frame_start, input ready);
    modport sink   (input valid, input frame_byte, input frame_start, output ready);
endinterface

interface phfd_field_if;
    logic               valid;
    logic               ready;
    logic [4:0]         field_code;
    logic [31:0]        raw_value;
    logic signed [14:0] scaled_value;
    logic [15:0]        crc_value;

    modport source (output valid, output field_code, output raw_value,
                    output scaled_value, output crc_value, input ready);
    modport sink   (input valid, input field_code, input raw_value,
                    input scaled_value, input crc_value, output ready);
endinterface

>>> src/phfd_cfg_regs.sv
// APB register file holding the CRC polynomial and CRC start value.
module phfd_cfg_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [phfd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    output phfd_pkg::phfd_cfg_t         cfg
);
    import phfd_pkg::*;

    logic [15:0] poly_reg;
    logic [15:0] init_reg;
    logic        wr_en;
    logic        reg_index;

    assign pready    = 1'b1;
    assign wr_en     = psel && penable && pwrite && pready;
    assign reg_index = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poly_reg <= CRC_POLY_RESET;
            init_reg <= CRC_INIT_RESET;
        end
        else if (wr_en && paddr[PADDR_W-1:2] == (PADDR_W-2)'(0) + (PADDR_W-2)'(reg_index))
        begin
            case (reg_index)
                REG_CRC_POLY: poly_reg <= pwdata[15:0];
                REG_CRC_INIT: init_reg <= pwdata[15:0];
                default:      poly_reg <= poly_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_CRC_POLY: prdata = {16'h0000, poly_reg};
            REG_CRC_INIT: prdata = {16'h0000, init_reg};
            default:      prdata = 32'h0000_0000;
        endcase
    end

    assign cfg.poly = poly_reg;
    assign cfg.init = init_reg;

endmodule

>>> src/phfd_frame_core.sv
// Byte position, field assembler and running CRC; decodes one byte per advance.
module phfd_frame_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   advance,
    input  logic [7:0]             frame_byte,
    input  logic                   frame_start,
    input  phfd_pkg::phfd_cfg_t    cfg,
    output phfd_pkg::phfd_result_t result
);
    import phfd_pkg::*;

    typedef enum logic [1:0] {
        LEN1 = 2'd0,
        LEN2 = 2'd1,
        LEN4 = 2'd2
    } len_t;

    // Reflected CRC over one byte, one shift per bit.
    function automatic logic [15:0] crc_update(input logic [15:0] crc_in,
                                               input logic [7:0]  b,
                                               input logic [15:0] poly);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        end
        return c;
    endfunction

    logic [POS_W-1:0] pos_reg, pos_next, pos_eff;
    logic [15:0]      crc_reg, crc_next, crc_eff, crc_new;
    logic [23:0]      asm_reg, asm_next, asm_eff;
    logic [POS_W-2:0] p;
    logic [POS_W-2:0] pm_off;
    logic             in_frame;
    logic             done;
    logic             big;
    logic [4:0]       code;
    len_t             len;
    logic [31:0]      raw;

    assign pos_eff  = frame_start ? '0 : pos_reg;
    assign crc_eff  = frame_start ? cfg.init : crc_reg;
    assign asm_eff  = frame_start ? 24'h0 : asm_reg;
    assign in_frame = (pos_eff < POS_W'(FRAME_BYTES));
    assign p        = pos_eff[POS_W-2:0];
    assign pm_off   = p - (POS_W-1)'(50);
    assign crc_new  = crc_update(crc_eff, frame_byte, cfg.poly);

    always_comb
    begin
        done = 1'b0;
        big  = 1'b0;
        code = CODE_BIN0;
        len  = LEN2;
        case (p) inside
            [6'd0:6'd31]:
            begin
                done = p[0];
                code = CODE_BIN0 + 5'(p[4:1]);
            end
            [6'd32:6'd35]:
            begin
                done = 1'b1;
                code = CODE_TOF0 + 5'(p[1:0]);
                len  = LEN1;
            end
            [6'd36:6'd39]:
            begin
                done = (p == 6'd39);
                code = CODE_FLOW;
                len  = LEN4;
            end
            [6'd40:6'd41]:
            begin
                done = (p == 6'd41);
                code = CODE_TEMP;
            end
            [6'd42:6'd43]:
            begin
                done = (p == 6'd43);
                code = CODE_HUMIDITY;
                big  = 1'b1;
            end
            [6'd44:6'd47]:
            begin
                done = (p == 6'd47);
                code = CODE_PERIOD;
                len  = LEN4;
            end
            [6'd48:6'd49]:
            begin
                done = 1'b1;
                code = CODE_REJECT0 + 5'(p[0]);
                len  = LEN1;
            end
            [6'd50:6'd61]:
            begin
                done = (pm_off[1:0] == 2'b11);
                code = CODE_PM0 + 5'(pm_off[3:2]);
                len  = LEN4;
            end
            default:
            begin
                done = (p == 6'd63);
                code = CODE_CHECKSUM;
                big  = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        case (len)
            LEN1:    raw = {24'h0, frame_byte};
            LEN2:    raw = big ? {16'h0, asm_eff[7:0], frame_byte}
                               : {16'h0, frame_byte, asm_eff[7:0]};
            LEN4:    raw = {frame_byte, asm_eff[7:0], asm_eff[15:8], asm_eff[23:16]};
            default: raw = 32'h0;
        endcase
    end

    always_comb
    begin
        pos_next = pos_eff;
        crc_next = crc_eff;
        asm_next = asm_eff;
        if (in_frame)
        begin
            pos_next = pos_eff + POS_W'(1);
            crc_next = crc_new;
            asm_next = done ? 24'h0 : {asm_eff[15:0], frame_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_W'(FRAME_BYTES);
            crc_reg <= CRC_INIT_RESET;
            asm_reg <= 24'h0;
        end
        else if (advance)
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            asm_reg <= asm_next;
        end
    end

    assign result.done = in_frame && done;
    assign result.code = code;
    assign result.raw  = raw;
    assign result.crc  = (code == CODE_CHECKSUM) ? crc_new : 16'h0000;

endmodule

>>> src/phfd_scale.sv
// Temperature and humidity scaling to hundredths, dividing by 65535 without a divider.
module phfd_scale (
    input  logic [4:0]         code,
    input  logic [15:0]        raw,
    output logic signed [14:0] scaled_value
);
    import phfd_pkg::*;

    localparam logic [14:0]        TEMP_SPAN   = 15'd17500;
    localparam logic [14:0]        HUM_SPAN    = 15'd10000;
    localparam logic signed [15:0] TEMP_OFFSET = -16'sd4500;
    localparam logic [31:0]        DIVISOR     = 32'd65535;

    logic [14:0]        span;
    logic [30:0]        product;
    logic [31:0]        sum_est;
    logic [15:0]        q_est;
    logic [31:0]        rem;
    logic [14:0]        quotient;
    logic signed [15:0] total;

    assign span    = (code == CODE_TEMP) ? TEMP_SPAN : HUM_SPAN;
    assign product = raw * span;

    // n/65535 is close to (n + n/65536)/65536; the estimate is at most one low,
    // and the remainder check fixes that.
    assign sum_est = {1'b0, product} + {17'h0, product[30:16]};
    assign q_est   = sum_est[31:16];
    assign rem     = {1'b0, product} - {q_est, 16'h0000} + {16'h0000, q_est};
    assign quotient = (rem >= DIVISOR) ? 15'(q_est + 16'd1) : q_est[14:0];

    always_comb
    begin
        case (code)
            CODE_TEMP:     total = TEMP_OFFSET + signed'({1'b0, quotient});
            CODE_HUMIDITY: total = signed'({1'b0, quotient});
            default:       total = 16'sd0;
        endcase
    end

    assign scaled_value = total[14:0];

endmodule

>>> src/particle_histogram_frame_decoder.sv
// Top level of the histogram frame decoder: input stage, decode core, result register.
//
//   channel   | dir | handshake        | beat
//   byte_in   | in  | valid/ready      | frame_byte, frame_start
//   field_out | out | valid/ready      | field_code, raw_value, scaled_value, crc_value
//   apb       | in  | psel/penable     | crc_polynomial at 0x0, crc_initial at 0x4
//
// One byte per cycle sustained while field_out is ready. The byte is registered in the
// input stage, then CRC update, field decode and scaling run combinationally into
// the result register. A stalled result holds the input stage; the input still
// takes a beat while its stage is empty or moves on. Reset puts the block outside a
// frame, waiting for a frame start; there is no clearing pass.
`include "particle_histogram_frame_decoder_defines.svh"

module particle_histogram_frame_decoder (
    input  logic                         clk,
    input  logic                         rst_n,
    phfd_byte_if.sink                    byte_in,
    phfd_field_if.source                 field_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [phfd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import phfd_pkg::*;

    phfd_cfg_t          cfg;
    phfd_result_t       result;
    logic signed [14:0] scaled;

    logic               s1_valid_reg;
    logic [7:0]         s1_byte_reg;
    logic               s1_start_reg;
    logic               s1_adv;

    logic               out_valid_reg;
    logic [4:0]         out_code_reg;
    logic [31:0]        out_raw_reg;
    logic signed [14:0] out_scaled_reg;
    logic [15:0]        out_crc_reg;

    phfd_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign s1_adv        = s1_valid_reg && (!out_valid_reg || field_out.ready);
    assign byte_in.ready = !s1_valid_reg || s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (byte_in.valid && byte_in.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            s1_byte_reg  <= byte_in.frame_byte;
            s1_start_reg <= byte_in.frame_start;
        end
    end

    phfd_frame_core u_frame_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (s1_adv),
        .frame_byte  (s1_byte_reg),
        .frame_start (s1_start_reg),
        .cfg         (cfg),
        .result      (result)
    );

    phfd_scale u_scale (
        .code         (result.code),
        .raw          (result.raw[15:0]),
        .scaled_value (scaled)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= result.done;
        end
        else if (field_out.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv && result.done)
        begin
            out_code_reg   <= result.code;
            out_raw_reg    <= result.raw;
            out_scaled_reg <= scaled;
            out_crc_reg    <= result.crc;
        end
    end

    assign field_out.valid        = out_valid_reg;
    assign field_out.field_code   = out_code_reg;
    assign field_out.raw_value    = out_raw_reg;
    assign field_out.scaled_value = out_scaled_reg;
    assign field_out.crc_value    = out_crc_reg;

    `PHFD_ASSERT_IMPLIES(a_crc_only_on_checksum, field_out.valid && field_out.field_code != CODE_CHECKSUM, field_out.crc_value == 16'h0000, "CRC reported on a field other than the checksum")
    `PHFD_ASSERT_IMPLIES(a_scaled_only_temp_hum, field_out.valid && field_out.field_code != CODE_TEMP && field_out.field_code != CODE_HUMIDITY, field_out.scaled_value == 15'sd0, "scaled value set on an unscaled field")
    `PHFD_ASSERT_IMPLIES(a_temp_floor, field_out.valid && field_out.field_code == CODE_TEMP, field_out.scaled_value >= -15'sd4500, "temperature below the scale floor")
    `PHFD_ASSERT_IMPLIES(a_stall_only_when_full, !byte_in.ready, s1_valid_reg && out_valid_reg && !field_out.ready, "input stalled while a stage is free")
    `PHFD_ASSERT_NEXT(a_result_from_stage, field_out.valid && !$past(field_out.valid), $past(s1_valid_reg, 2), "result appeared without a registered beat")

endmodule

>>> sim/histogram_field_checker.sv
// Scoreboard for the histogram frame decoder: predicts every decoded field and checks it.
module histogram_field_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    phfd_byte_if                         byte_in,
    phfd_field_if                        field_out,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic                         pready,
    input  logic [phfd_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output int                           failures,
    output int                           fields_pending
);
    import phfd_pkg::*;

    typedef struct packed {
        logic [4:0]         code;
        logic [31:0]        raw;
        logic signed [14:0] scaled;
        logic [15:0]        crc;
    } field_beat_t;

    logic [15:0]      poly_reg;
    logic [15:0]      init_reg;
    logic [POS_W-1:0] frame_pos;
    logic [15:0]      frame_crc;
    logic [23:0]      partial_field;
    field_beat_t      awaited_fields[$];

    function automatic logic [15:0] crc_after_byte(input logic [15:0] crc,
                                                   input logic [7:0]  value,
                                                   input logic [15:0] poly);
        logic [15:0] c;
        int          i;
        c = crc ^ {8'h00, value};
        for (i = 0; i < 8; i++)
            c = c[0] ? ((c >> 1) ^ poly) : (c >> 1);
        return c;
    endfunction

    // Advances the frame state by one byte and queues the field that it completes, if any.
    task automatic decode_frame_byte(input logic [7:0] value, input logic start);
        logic [POS_W-1:0] pos;
        logic [4:0]       code;
        int               len;
        logic             last;
        logic             msb_first;
        field_beat_t      f;
        if (start)
        begin
            frame_pos     = '0;
            frame_crc     = init_reg;
            partial_field = '0;
        end
        if (frame_pos >= FRAME_BYTES)
            return;
        frame_crc = crc_after_byte(frame_crc, value, poly_reg);
        pos       = frame_pos;
        frame_pos = pos + 1'b1;
        msb_first = 1'b0;
        // Byte offsets of the fields within the frame.
        if (pos < 32)
        begin
            last = pos[0];
            code = CODE_BIN0 + 5'(pos >> 1);
            len  = 2;
        end
        else if (pos < 36)
        begin
            last = 1'b1;
            code = CODE_TOF0 + 5'(pos - 32);
            len  = 1;
        end
        else if (pos < 40)
        begin
            last = (pos == 39);
            code = CODE_FLOW;
            len  = 4;
        end
        else if (pos < 42)
        begin
            last = (pos == 41);
            code = CODE_TEMP;
            len  = 2;
        end
        else if (pos < 44)
        begin
            last      = (pos == 43);
            code      = CODE_HUMIDITY;
            len       = 2;
            msb_first = 1'b1;
        end
        else if (pos < 48)
        begin
            last = (pos == 47);
            code = CODE_PERIOD;
            len  = 4;
        end
        else if (pos < 50)
        begin
            last = 1'b1;
            code = CODE_REJECT0 + 5'(pos - 48);
            len  = 1;
        end
        else if (pos < 62)
        begin
            last = ((pos - 50) % 4 == 3);
            code = CODE_PM0 + 5'((pos - 50) / 4);
            len  = 4;
        end
        else
        begin
            last      = (pos == 63);
            code      = CODE_CHECKSUM;
            len       = 2;
            msb_first = 1'b1;
        end

        if (!last)
        begin
            partial_field = {partial_field[15:0], value};
            return;
        end

        f.code = code;
        case (len)
            1: f.raw = {24'h0, value};
            2: f.raw = msb_first ? {16'h0, partial_field[7:0], value}
                                 : {16'h0, value, partial_field[7:0]};
            default: f.raw = {value, partial_field[7:0], partial_field[15:8],
                              partial_field[23:16]};
        endcase
        partial_field = '0;

        f.scaled = '0;
        if (code == CODE_TEMP)
            f.scaled = 15'(-4500 + int'((32'd17500 * f.raw) / 32'd65535));
        else if (code == CODE_HUMIDITY)
            f.scaled = 15'(int'((32'd10000 * f.raw) / 32'd65535));
        f.crc = (code == CODE_CHECKSUM) ? frame_crc : 16'h0000;
        awaited_fields.push_back(f);
    endtask

    task automatic compare_field(input string name, input longint want, input longint got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        field_beat_t want;
        if (!rst_n)
        begin
            poly_reg      = CRC_POLY_RESET;
            init_reg      = CRC_INIT_RESET;
            frame_pos     = POS_W'(FRAME_BYTES);
            frame_crc     = CRC_INIT_RESET;
            partial_field = '0;
            awaited_fields.delete();
            failures      = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr[PADDR_W-1:2] == REG_CRC_POLY)
                    poly_reg = pwdata[15:0];
                else if (paddr[PADDR_W-1:2] == REG_CRC_INIT)
                    init_reg = pwdata[15:0];
            end

            if (field_out.valid && field_out.ready)
            begin
                if (awaited_fields.size() == 0)
                begin
                    $error("field beat with code %0d arrived while none was expected",
                           field_out.field_code);
                    failures++;
                end
                else
                begin
                    want = awaited_fields.pop_front();
                    compare_field("field_code", want.code, field_out.field_code);
                    compare_field("raw_value", want.raw, field_out.raw_value);
                    compare_field("scaled_value", longint'($signed(want.scaled)),
                                  longint'($signed(field_out.scaled_value)));
                    compare_field("crc_value", want.crc, field_out.crc_value);
                end
            end

            if (byte_in.valid && byte_in.ready)
                decode_frame_byte(byte_in.frame_byte, byte_in.frame_start);
        end
        fields_pending = awaited_fields.size();
    end

endmodule

>>> sim/tb_particle_histogram_frame_decoder.sv
// Testbench top of the histogram frame decoder: byte stimulus, register writes and verdict.
module tb_particle_histogram_frame_decoder;
    import phfd_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int PHASES          = 8;
    localparam int BYTES_PER_PHASE = 170;

    logic               clk;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    int failures;
    int fields_pending;
    int cycle_count = 0;
    int idle_pct;
    int stall_pct;

    phfd_byte_if  byte_ch();
    phfd_field_if field_ch();

    particle_histogram_frame_decoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_ch),
        .field_out (field_ch),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    histogram_field_checker field_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_in        (byte_ch),
        .field_out      (field_ch),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .pready         (pready),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .failures       (failures),
        .fields_pending (fields_pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(negedge clk)
        field_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Entered and left at a falling edge; the beat is held until it is taken.
    task automatic send_byte(input logic [7:0] value, input logic start);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            byte_ch.valid = 1'b0;
            @(negedge clk);
        end
        byte_ch.valid       = 1'b1;
        byte_ch.frame_byte  = value;
        byte_ch.frame_start = start;
        @(posedge clk);
        while (!byte_ch.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Some frames use only all-zero and all-one bytes to reach the scaling extremes.
    task automatic send_frame(input int length);
        logic [7:0] value;
        bit         rails;
        int         i;
        rails = ($urandom_range(0, 3) == 0);
        for (i = 0; i < length; i++)
        begin
            if (rails)
                value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                value = 8'($urandom);
            send_byte(value, i == 0);
        end
    endtask

    task automatic write_register(input logic reg_index, input logic [15:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = PADDR_W'({reg_index, 2'b00});
        pwdata  = {16'($urandom), value};
        @(negedge clk);
        penable = 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // A byte that completes no field can still sit in the input stage, hence the extra cycles.
    task automatic wait_drained();
        byte_ch.valid = 1'b0;
        while (fields_pending != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);
    endtask

    initial
    begin
        int         phase;
        int         sent;
        int         kind;
        int         length;
        int         i;
        logic [7:0] value;
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        byte_ch.valid       = 1'b0;
        byte_ch.frame_byte  = 8'h00;
        byte_ch.frame_start = 1'b0;
        idle_pct            = 0;
        stall_pct           = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Out of a frame after reset, so these bytes are ignored.
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h5A, 1'b0);
        // A frame cut short by a new frame start after its third byte.
        send_byte(8'h12, 1'b1);
        send_byte(8'h34, 1'b0);
        send_byte(8'hFF, 1'b0);
        for (i = 0; i < FRAME_BYTES; i++)
        begin
            case (i)
                40, 41:  value = 8'hFF;
                42, 43:  value = 8'h00;
                default: value = (i % 3 == 0) ? 8'h00 : (i % 3 == 1) ? 8'hFF : 8'(i * 37 + 5);
            endcase
            send_byte(value, i == 0);
        end
        // Past the end of the frame: ignored.
        send_byte(8'hA5, 1'b0);
        send_byte(8'h00, 1'b0);

        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            case (phase)
                0: ;
                1:
                begin
                    write_register(REG_CRC_POLY, 16'h0000);
                    write_register(REG_CRC_INIT, 16'h0000);
                end
                2:
                begin
                    write_register(REG_CRC_POLY, 16'hFFFF);
                    write_register(REG_CRC_INIT, 16'hFFFF);
                end
                3:
                begin
                    write_register(REG_CRC_POLY, CRC_POLY_RESET);
                    write_register(REG_CRC_INIT, CRC_INIT_RESET);
                end
                default:
                begin
                    write_register(REG_CRC_POLY, 16'($urandom));
                    write_register(REG_CRC_INIT, 16'($urandom));
                end
            endcase
            case (phase % 4)
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 61;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 61;
                end
                default:
                begin
                    idle_pct  = 11;
                    stall_pct = 11;
                end
            endcase

            sent = 0;
            while (sent < BYTES_PER_PHASE)
            begin
                kind = $urandom_range(0, 9);
                if (kind == 0)
                begin
                    repeat ($urandom_range(1, 4))
                        send_byte(8'($urandom), 1'b0);
                end
                else if (kind == 1)
                begin
                    length = $urandom_range(1, FRAME_BYTES - 1);
                    send_frame(length);
                    sent += length;
                end
                else
                begin
                    send_frame(FRAME_BYTES);
                    sent += FRAME_BYTES;
                end
            end
        end

        idle_pct  = 0;
        stall_pct = 0;
        wait_drained();
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+src
src/phfd_pkg.sv
src/phfd_if.sv
src/phfd_cfg_regs.sv
src/phfd_frame_core.sv
src/phfd_scale.sv
src/particle_histogram_frame_decoder.sv
sim/histogram_field_checker.sv
sim/tb_particle_histogram_frame_decoder.sv
